[design/emu_pkg.sv]
// ----------------------------------------------------------------------------
// emu_pkg
// Shared types and constants for the encoder motion estimator.
// ----------------------------------------------------------------------------
package emu_pkg;

  localparam logic [1:0]  CFG_CPR    = 2'd0;
  localparam logic [1:0]  CFG_OFFSET = 2'd1;
  localparam logic [1:0]  CFG_VEL_W  = 2'd2;
  localparam logic [1:0]  CFG_ACC_W  = 2'd3;

  // 2*pi in Q32, split for two narrow partial products
  localparam logic [34:0] TWO_PI_Q32 = 35'h6487ED511;
  localparam logic [17:0] K_LO       = TWO_PI_Q32[17:0];
  localparam logic [16:0] K_HI       = TWO_PI_Q32[34:18];
  localparam logic [19:0] US_PER_S   = 20'd1000000;

  localparam int          PROD_W     = 69;
  localparam logic [6:0]  DIV_LAST   = 7'd68;

  typedef struct packed {
    logic [23:0] cpr;
    logic [23:0] offset;
    logic [16:0] vel_w;
    logic [16:0] acc_w;
  } emu_cfg_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [24:0] sc;
    logic               neg;
    logic [23:0]        mag;
    logic               ch_ok;
    logic [15:0]        ee;
  } emu_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MA0, ST_MA1, ST_RM0, ST_RM1, ST_DIV, ST_DFIN,
    ST_SM0, ST_SM1, ST_SFIN, ST_OUT
  } emu_state_t;

  typedef enum logic [1:0] {
    KIND_ANG, KIND_VEL, KIND_ACC
  } emu_kind_t;

endpackage

[design/emu_front.sv]
// ----------------------------------------------------------------------------
// emu_front
// Input handshake and classification: offset removal, sign/magnitude split,
// channel range check, zero-time fixup.
// ----------------------------------------------------------------------------
module emu_front import emu_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  emu_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_channel,
  input  logic [23:0] in_raw_count,
  input  logic [15:0] in_elapsed_us,
  input  logic        q_full,
  output logic        q_push,
  output emu_ent_t    q_ent
);

  logic signed [24:0] sc;
  logic        [24:0] sc_neg;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    sc              = $signed({1'b0, in_raw_count}) - $signed({1'b0, cfg.offset});
    sc_neg          = -sc;
    q_ent.channel   = in_channel;
    q_ent.sc        = sc;
    q_ent.neg       = sc[24];
    q_ent.mag       = sc[24] ? sc_neg[23:0] : sc[23:0];
    q_ent.ch_ok     = ({29'd0, in_channel} < CHANNELS);
    q_ent.ee        = (in_elapsed_us == 16'd0) ? 16'd1 : in_elapsed_us;
  end

endmodule

[design/emu_queue.sv]
// ----------------------------------------------------------------------------
// emu_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module emu_queue import emu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  emu_ent_t wr_ent,
  input  logic     pop,
  output emu_ent_t rd_ent,
  output logic     full,
  output logic     vld
);

  emu_ent_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign vld    = (cnt_r != 2'd0);
  assign rd_ent = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/emu_back.sv]
// ----------------------------------------------------------------------------
// emu_back
// Sequencer: angle, two rate divisions, two filters, per-channel state,
// output register.
// ----------------------------------------------------------------------------
module emu_back import emu_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  emu_cfg_t           cfg,
  input  logic               q_vld,
  input  emu_ent_t           q_ent,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_channel,
  output logic signed [24:0] out_signed_count,
  output logic signed [47:0] out_angle,
  output logic signed [47:0] out_speed,
  output logic signed [47:0] out_accel
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic [47:0] sat48(input logic neg, input logic [PROD_W-1:0] mag);
    logic [47:0] res;
    if (neg) begin
      if (mag >= {21'd0, 1'b1, 47'd0}) res = {1'b1, 47'd0};
      else                             res = -mag[47:0];
    end else begin
      if (mag > {22'd0, {47{1'b1}}}) res = {1'b0, {47{1'b1}}};
      else                            res = mag[47:0];
    end
    return res;
  endfunction

  function automatic logic [48:0] sdiff(input logic [47:0] a, input logic [47:0] b);
    return {a[47], a} - {b[47], b};
  endfunction

  emu_state_t  state_r, state_nxt;
  emu_kind_t   kind_r;
  emu_ent_t    ent_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] dvd_r;
  logic [23:0] rem_r;
  logic [23:0] dvs_r;
  logic [6:0]  cnt_r;
  logic [47:0] ang_r, old_spd_r, spd_r, acc_r, sold_r, sx_r;
  logic        dneg_r;
  logic [48:0] dmag_r;
  logic [47:0] last_ang_r [CHANNELS];
  logic [47:0] fspd_r     [CHANNELS];
  logic [47:0] facc_r     [CHANNELS];
  logic        out_valid_r;
  logic [2:0]  out_channel_r;
  logic [24:0] out_sc_r;
  logic [47:0] out_ang_r, out_spd_r, out_acc_r;

  logic [CH_W-1:0] idx;
  logic [24:0] rem_sh;
  logic        ge;
  logic [24:0] rem_sub;
  logic [PROD_W-1:0] ang_q;
  logic [47:0] ang_val, rate_val, sm_val;
  logic [16:0] cur_w;
  logic [48:0] step;
  logic [48:0] sm_sum;
  logic [41:0] p_ang_lo;
  logic [40:0] p_ang_hi;
  logic [44:0] p_m_lo;
  logic [43:0] p_m_hi;
  logic [40:0] p_w_lo;
  logic [39:0] p_w_hi;
  logic [48:0] d_ang, d_vel, d_acc, d_spd;
  logic        out_load;

  always_comb begin
    idx      = CH_W'(ent_r.channel);
    rem_sh   = {rem_r, dvd_r[PROD_W-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_sub  = rem_sh - {1'b0, dvs_r};
    ang_q    = dvd_r + 69'd128;
    ang_val  = sat48(ent_r.neg, {8'd0, ang_q[PROD_W-1:8]});
    rate_val = sat48(dneg_r, dvd_r);
    cur_w    = (kind_r == KIND_VEL) ? cfg.vel_w : cfg.acc_w;
    p_ang_lo = ent_r.mag * K_LO;
    p_ang_hi = ent_r.mag * K_HI;
    p_m_lo   = dmag_r[24:0] * US_PER_S;
    p_m_hi   = dmag_r[48:25] * US_PER_S;
    p_w_lo   = dmag_r[24:0] * cur_w[15:0];
    p_w_hi   = dmag_r[48:25] * cur_w[15:0];
    step     = prod_r[64:16];
    sm_sum   = dneg_r ? ({sold_r[47], sold_r} - step) : ({sold_r[47], sold_r} + step);
    sm_val   = cur_w[16] ? sx_r : sm_sum[47:0];
    d_ang    = sdiff(ang_val, last_ang_r[idx]);
    d_vel    = sdiff(rate_val, old_spd_r);
    d_acc    = sdiff(rate_val, facc_r[idx]);
    d_spd    = sdiff(sm_val, old_spd_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_vld) state_nxt = ST_MA0;
      ST_MA0:  state_nxt = ST_MA1;
      ST_MA1:  state_nxt = ST_DIV;
      ST_RM0:  state_nxt = ST_RM1;
      ST_RM1:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == DIV_LAST) state_nxt = ST_DFIN;
      ST_DFIN: begin
        if (kind_r == KIND_ANG) state_nxt = ent_r.ch_ok ? ST_RM0 : ST_OUT;
        else                    state_nxt = ST_SM0;
      end
      ST_SM0:  state_nxt = ST_SM1;
      ST_SM1:  state_nxt = ST_SFIN;
      ST_SFIN: state_nxt = (kind_r == KIND_VEL) ? ST_RM0 : ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = (state_r == ST_IDLE) && q_vld;
    out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_ANG;
    end else begin
      case (state_r)
        ST_IDLE: begin
          ent_r  <= q_ent;
          kind_r <= KIND_ANG;
        end
        ST_MA0: prod_r <= {27'd0, p_ang_lo};
        ST_MA1: begin
          dvd_r <= prod_r + {10'd0, p_ang_hi, 18'd0};
          dvs_r <= (cfg.cpr == 24'd0) ? 24'd1 : cfg.cpr;
          rem_r <= 24'd0;
          cnt_r <= 7'd0;
        end
        ST_RM0: prod_r <= {24'd0, p_m_lo} + {54'd0, ent_r.ee[15:1]};
        ST_RM1: begin
          dvd_r <= prod_r + {p_m_hi, 25'd0};
          dvs_r <= {8'd0, ent_r.ee};
          rem_r <= 24'd0;
          cnt_r <= 7'd0;
        end
        ST_DIV: begin
          dvd_r <= {dvd_r[PROD_W-2:0], ge};
          rem_r <= ge ? rem_sub[23:0] : rem_sh[23:0];
          cnt_r <= cnt_r + 7'd1;
        end
        ST_DFIN: begin
          case (kind_r)
            KIND_ANG: begin
              ang_r     <= ang_val;
              spd_r     <= 48'd0;
              acc_r     <= 48'd0;
              old_spd_r <= fspd_r[idx];
              dneg_r    <= d_ang[48];
              dmag_r    <= d_ang[48] ? -d_ang : d_ang;
              kind_r    <= KIND_VEL;
            end
            KIND_VEL: begin
              sold_r <= old_spd_r;
              sx_r   <= rate_val;
              dneg_r <= d_vel[48];
              dmag_r <= d_vel[48] ? -d_vel : d_vel;
            end
            default: begin
              sold_r <= facc_r[idx];
              sx_r   <= rate_val;
              dneg_r <= d_acc[48];
              dmag_r <= d_acc[48] ? -d_acc : d_acc;
            end
          endcase
        end
        ST_SM0: prod_r <= {28'd0, p_w_lo} + 69'd32768;
        ST_SM1: prod_r <= prod_r + {4'd0, p_w_hi, 25'd0};
        ST_SFIN: begin
          if (kind_r == KIND_VEL) begin
            spd_r  <= sm_val;
            dneg_r <= d_spd[48];
            dmag_r <= d_spd[48] ? -d_spd : d_spd;
            kind_r <= KIND_ACC;
          end else begin
            acc_r <= sm_val;
          end
        end
        default: ;
      endcase
    end
  end

  // per-channel history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_ang_r[i] <= 48'd0;
        fspd_r[i]     <= 48'd0;
        facc_r[i]     <= 48'd0;
      end
    end else if (state_r == ST_SFIN && kind_r == KIND_ACC) begin
      last_ang_r[idx] <= ang_r;
      fspd_r[idx]     <= spd_r;
      facc_r[idx]     <= sm_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel_r <= ent_r.channel;
      out_sc_r      <= ent_r.sc;
      out_ang_r     <= ang_r;
      out_spd_r     <= spd_r;
      out_acc_r     <= acc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_signed_count = out_sc_r;
  assign out_angle        = out_ang_r;
  assign out_speed        = out_spd_r;
  assign out_accel        = out_acc_r;

endmodule

[design/encoder_motion_estimator_unit.sv]
// ----------------------------------------------------------------------------
// encoder_motion_estimator_unit
// Per-channel angle, filtered velocity and filtered acceleration from
// latched encoder counts, signed Q24.24 outputs with saturation.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall  in_channel, in_raw_count, in_elapsed_us
// out_     output     out_valid/out_stall out_channel, out_signed_count,
//                                        out_angle, out_speed, out_accel
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Sequencing: one item at a time; an out-of-range channel runs the angle division only.
//   One shared radix-2 divider (69 steps) runs up to three times per item:
//   angle, velocity rate, acceleration rate.
// Reset: rst_n synchronous active low; history of all channels clears at once.
// Stalls: a 2-entry queue decouples input from the sequencer, and the output
//   register lets the next item compute while a result waits.
// ----------------------------------------------------------------------------
module encoder_motion_estimator_unit import emu_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_channel,
  input  logic [23:0]        in_raw_count,
  input  logic [15:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_channel,
  output logic signed [24:0] out_signed_count,
  output logic signed [47:0] out_angle,
  output logic signed [47:0] out_speed,
  output logic signed [47:0] out_accel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  emu_cfg_t cfg_r;
  emu_ent_t fr_ent, q_ent;
  logic     q_push, q_pop, q_full, q_vld;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpr    <= 24'd2000;
      cfg_r.offset <= 24'd8388608;
      cfg_r.vel_w  <= 17'd3932;
      cfg_r.acc_w  <= 17'd3932;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CPR:    cfg_r.cpr    <= cfg_data;
        CFG_OFFSET: cfg_r.offset <= cfg_data;
        CFG_VEL_W:  cfg_r.vel_w  <= cfg_data[16:0];
        CFG_ACC_W:  cfg_r.acc_w  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  emu_front #(.CHANNELS(CHANNELS)) u_front (
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_channel    (in_channel),
    .in_raw_count  (in_raw_count),
    .in_elapsed_us (in_elapsed_us),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ent         (fr_ent)
  );

  emu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_ent (fr_ent),
    .pop    (q_pop),
    .rd_ent (q_ent),
    .full   (q_full),
    .vld    (q_vld)
  );

  emu_back #(.CHANNELS(CHANNELS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_vld            (q_vld),
    .q_ent            (q_ent),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_signed_count (out_signed_count),
    .out_angle        (out_angle),
    .out_speed        (out_speed),
    .out_accel        (out_accel)
  );

`ifndef SYNTHESIS
  // out-of-range channel carries no motion
  a_bad_ch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ({29'd0, out_channel} >= CHANNELS))
      |-> (out_speed == 48'sd0 && out_accel == 48'sd0))
    else $error("motion on out-of-range channel");

  // zero count maps to zero angle
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_signed_count == 25'sd0) |-> (out_angle == 48'sd0))
    else $error("nonzero angle for zero count");

  // angle sign follows count sign
  a_angle_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_signed_count > 25'sd0) |-> !out_angle[47])
    else $error("angle sign mismatch");
`endif

endmodule
